// File: rtl/core/assert_macros.svh
// Assertion macros shared by the waveshaper RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define PWS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Property must never hold at a clock edge outside reset.
`define PWS_ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
        else $error("forbidden condition seen");
`else
`define PWS_ASSERT(label, clk, rst_n, prop)
`define PWS_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// File: rtl/core/pws_pkg.sv
// Package of the piecewise waveshaper: sizes, request codes and the token
// that travels down the segment chain. Depends on nothing.
package pws_pkg;

    localparam int SEGMENTS = 16;
    localparam int SEG_W    = (SEGMENTS > 2) ? $clog2(SEGMENTS) : 1;
    localparam int IDX_W    = (SEG_W > 4) ? SEG_W : 4;

    localparam int SAMPLE_W = 16;
    localparam int SLOPE_W  = 17;
    localparam int ICPT_W   = 35;
    localparam int PROD_W   = SAMPLE_W + SLOPE_W + 1;
    localparam int SUM_W    = 36;

    localparam logic ACTION_SHAPE = 1'b0;
    localparam logic ACTION_LOAD  = 1'b1;

    // One request as it moves from cell to cell. The load fields are used by
    // the cell whose number matches seg_index; the sel_* fields carry the
    // segment picked so far for a shape request.
    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [3:0]                 seg_index;
        logic signed [SAMPLE_W-1:0] breakpoint;
        logic [SLOPE_W-1:0]         slope;
        logic signed [ICPT_W-1:0]   intercept;
        logic                       found;
        logic [SEG_W-1:0]           seg;
        logic [SLOPE_W-1:0]         sel_slope;
        logic signed [ICPT_W-1:0]   sel_icpt;
    } t_token;

endpackage

// File: rtl/core/piecewise_waveshaper_search_unit.sv
// Top level of the piecewise waveshaper: a chain of segment cells followed
// by the output arithmetic. Depends on pws_pkg, pws_cell, pws_arith and assert_macros.svh.
//
// Diode-like piecewise linear waveshaper for 16-bit audio. Every request,
// load or shape, enters a chain of SEGMENTS cells, one cell per curve
// segment, and moves one cell per cycle whenever the pipeline advances. A
// load request writes the breakpoint, slope and intercept into the cell
// whose number equals seg_index as it passes; a load with an index beyond
// the chain writes nothing. A shape request picks the first cell whose
// breakpoint is at least the sample (the last cell if none is), then passes
// through three arithmetic stages: multiply, add intercept, divide by 2^16
// toward zero with saturation. Because loads and samples travel in order
// through the same cells, a sample always sees every load issued before it.
// The block takes one request per cycle unless stalled; a result passes
// through the SEGMENTS cell registers and then three arithmetic registers.
// The whole pipeline advances together and halts only while a result
// waits at the output and the downstream i_ready is low; o_ready is low in
// exactly those cycles. Load requests produce no result. All segments used
// by samples must be loaded first; table cells have no reset.
`include "assert_macros.svh"
module piecewise_waveshaper_search_unit
    import pws_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [3:0]                 i_seg_index,
    input  logic signed [SAMPLE_W-1:0] i_breakpoint,
    input  logic [SLOPE_W-1:0]         i_slope,
    input  logic signed [ICPT_W-1:0]   i_intercept,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_shaped,
    output logic [3:0]                 o_segment_used
);

    // Global advance: everything moves unless a finished result is stuck.
    logic   w_en;
    logic   w_valid [SEGMENTS+1];
    t_token w_tok   [SEGMENTS+1];
    t_token w_tok_in;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Request as it enters the first cell: nothing selected yet.
    always_comb begin
        w_tok_in            = '0;
        w_tok_in.action     = i_action;
        w_tok_in.sample     = i_sample;
        w_tok_in.seg_index  = i_seg_index;
        w_tok_in.breakpoint = i_breakpoint;
        w_tok_in.slope      = i_slope;
        w_tok_in.intercept  = i_intercept;
    end
    assign w_tok[0]   = w_tok_in;
    assign w_valid[0] = i_valid;

    // The chain of segment cells.
    for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
        pws_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_cell_id (SEG_W'(g)),
            .i_valid   (w_valid[g]),
            .i_tok     (w_tok[g]),
            .o_valid   (w_valid[g+1]),
            .o_tok     (w_tok[g+1])
        );
    end

    // Multiply, offset, scale and saturate the selected segment.
    pws_arith u_arith (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_valid[SEGMENTS]),
        .i_tok          (w_tok[SEGMENTS]),
        .o_valid        (o_valid),
        .o_shaped       (o_shaped),
        .o_segment_used (o_segment_used)
    );

    // A shape request leaving the chain has always picked a segment.
    `PWS_ASSERT_NEVER(a_unpicked_shape, i_clk, i_rst_n, w_valid[SEGMENTS] && (w_tok[SEGMENTS].action == ACTION_SHAPE) && !w_tok[SEGMENTS].found)
    // While stalled the tail of the chain does not move.
    `PWS_ASSERT(a_chain_holds, i_clk, i_rst_n, !w_en |=> $stable(w_valid[SEGMENTS]))

endmodule

// File: rtl/core/pws_cell.sv
// One cell of the segment chain: holds one curve segment and passes the
// request token on to its neighbor. Depends on pws_pkg.
module pws_cell
    import pws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [SEG_W-1:0] i_cell_id,
    input  logic             i_valid,
    input  t_token           i_tok,
    output logic             o_valid,
    output t_token           o_tok
);

    logic signed [SAMPLE_W-1:0] r_bp;
    logic [SLOPE_W-1:0]         r_slope;
    logic signed [ICPT_W-1:0]   r_icpt;
    logic                       r_valid;
    t_token                     r_tok;
    t_token                     n_tok;
    logic                       w_load_hit;
    logic                       w_is_last;
    logic                       w_pick;

    assign w_load_hit = i_valid && (i_tok.action == ACTION_LOAD) &&
                        (IDX_W'(i_tok.seg_index) == IDX_W'(i_cell_id));
    assign w_is_last  = (i_cell_id == SEG_W'(SEGMENTS - 1));
    assign w_pick     = (i_tok.action == ACTION_SHAPE) && !i_tok.found &&
                        ((i_tok.sample <= r_bp) || w_is_last);

    always_comb begin
        n_tok = i_tok;
        if (w_pick) begin
            n_tok.found     = 1'b1;
            n_tok.seg       = i_cell_id;
            n_tok.sel_slope = r_slope;
            // The first segment always runs through the origin.
            n_tok.sel_icpt  = (i_cell_id == '0) ? '0 : r_icpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_load_hit) begin
            r_bp    <= i_tok.breakpoint;
            r_slope <= i_tok.slope;
            r_icpt  <= i_tok.intercept;
        end
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// File: rtl/core/pws_arith.sv
// Output arithmetic of the waveshaper: multiply, add intercept, divide by
// 2^16 toward zero and saturate. Depends on pws_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pws_arith
    import pws_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_token                     i_tok,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_shaped,
    output logic [3:0]                 o_segment_used
);

    logic                       r_mul_v;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ICPT_W-1:0]   r_mul_icpt;
    logic [SEG_W-1:0]           r_mul_seg;
    logic                       r_add_v;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SEG_W-1:0]           r_add_seg;
    logic                       r_out_v;
    logic signed [SAMPLE_W-1:0] r_shaped;
    logic [SEG_W-1:0]           r_out_seg;

    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]    w_adj;
    logic signed [SUM_W-17:0]   w_quot;
    logic signed [SAMPLE_W-1:0] n_shaped;

    assign w_prod = i_tok.sample * $signed({1'b0, i_tok.sel_slope});

    // Negative sums get a bias of 2^16-1 so the shift truncates toward zero.
    assign w_adj  = r_sum + (r_sum[SUM_W-1] ? SUM_W'(65535) : SUM_W'(0));
    assign w_quot = w_adj[SUM_W-1:16];

    always_comb begin
        if (w_quot > $signed((SUM_W-16)'(32767))) begin
            n_shaped = 16'sh7fff;
        end else if (w_quot < -$signed((SUM_W-16)'(32768))) begin
            n_shaped = 16'sh8000;
        end else begin
            n_shaped = w_quot[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= w_prod;
            r_mul_icpt <= i_tok.sel_icpt;
            r_mul_seg  <= i_tok.seg;
            r_sum      <= {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} +
                          {{(SUM_W-ICPT_W){r_mul_icpt[ICPT_W-1]}}, r_mul_icpt};
            r_add_seg  <= r_mul_seg;
            r_shaped   <= n_shaped;
            r_out_seg  <= r_add_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_add_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            // Load requests leave the pipeline here without a result.
            r_mul_v <= i_valid && (i_tok.action == ACTION_SHAPE);
            r_add_v <= r_mul_v;
            r_out_v <= r_add_v;
        end
    end

    assign o_valid        = r_out_v;
    assign o_shaped       = r_shaped;
    assign o_segment_used = 4'(r_out_seg);

    `PWS_ASSERT(a_out_follows_add, i_clk, i_rst_n, i_en |=> (r_out_v == $past(r_add_v)))
    `PWS_ASSERT(a_stall_holds, i_clk, i_rst_n, !i_en |=> ($stable(r_add_v) && $stable(r_sum)))
    `PWS_ASSERT_NEVER(a_sign_flip, i_clk, i_rst_n, i_en && r_add_v && !r_sum[SUM_W-1] ##1 o_shaped[SAMPLE_W-1])

endmodule

// File: dv/tb_piecewise_waveshaper_search_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_waveshaper_search_unit: curve loads and
// sample requests are driven with random idling and checked against a predictor.
// Depends on pws_pkg and the RTL of the waveshaper.
module tb_piecewise_waveshaper_search_unit
    import pws_pkg::*;
();

    // The chain is SEGMENTS cells plus three arithmetic stages deep.
    localparam int LATENCY        = SEGMENTS + 3;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 700;
    localparam int LIMIT_CYCLES   = 300000;
    localparam int LONG_HOLD      = 300;

    localparam longint ICPT_MAX = (64'sd1 <<< (ICPT_W - 1)) - 1;
    localparam longint ICPT_MIN = -(64'sd1 <<< (ICPT_W - 1));
    localparam longint Y_LIMIT  = 64'sd32767 * 64'sd65536;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_STINGY} t_rx_mode;

    // One request as the sender offers it. hold_until_drained makes the
    // sender pause until every pending shaped sample has come back.
    typedef struct {
        logic                       action;
        logic signed [SAMPLE_W-1:0] smp;
        logic [3:0]                 seg_index;
        logic signed [SAMPLE_W-1:0] bp;
        logic [SLOPE_W-1:0]         slope;
        logic signed [ICPT_W-1:0]   icpt;
        bit                         hold_until_drained;
    } t_request;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [SAMPLE_W-1:0] shaped;
        logic [3:0]                 seg;
    } t_shape_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_action = ACTION_SHAPE;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic [3:0]                 i_seg_index = '0;
    logic signed [SAMPLE_W-1:0] i_breakpoint = '0;
    logic [SLOPE_W-1:0]         i_slope = '0;
    logic signed [ICPT_W-1:0]   i_intercept = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_shaped;
    logic [3:0]                 o_segment_used;

    piecewise_waveshaper_search_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_sample       (i_sample),
        .i_seg_index    (i_seg_index),
        .i_breakpoint   (i_breakpoint),
        .i_slope        (i_slope),
        .i_intercept    (i_intercept),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_shaped       (o_shaped),
        .o_segment_used (o_segment_used)
    );

    // Requests waiting to be offered, and the shaped samples still owed by the block.
    t_request      pending_q[$];
    t_shape_result shaped_q[$];
    t_request      cur_req;

    // Predictor copy of the curve, updated in acceptance order.
    logic signed [SAMPLE_W-1:0] curve_bp[SEGMENTS];
    logic [SLOPE_W-1:0]         curve_slope[SEGMENTS];
    logic signed [ICPT_W-1:0]   curve_icpt[SEGMENTS];

    // Breakpoints as the stimulus generator last queued them, used to aim
    // samples right at segment edges.
    logic signed [SAMPLE_W-1:0] gen_bp[SEGMENTS];

    int  n_queued;
    int  n_loads;
    int  n_samples;
    int  n_results;
    int  n_saturated;
    int  n_errors;
    int  n_long_holds;
    int  cycle_count;
    bit  seg_seen[SEGMENTS];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        n_errors++;
    endtask

    // Shape one sample against the current curve: the first segment whose
    // breakpoint is at least the sample wins, otherwise the last segment.
    // Segment 0 never adds its intercept. The quotient truncates toward zero
    // and is clamped to the signed 16-bit range.
    function automatic t_shape_result shape_sample(input logic signed [SAMPLE_W-1:0] x);
        t_shape_result r;
        int            seg;
        bit            hit;
        longint        acc;
        longint        y;
        seg = SEGMENTS - 1;
        hit = 1'b0;
        for (int j = 0; j < SEGMENTS; j++) begin
            if (!hit && x <= curve_bp[j]) begin
                seg = j;
                hit = 1'b1;
            end
        end
        acc = longint'(x) * longint'(curve_slope[seg]);
        if (seg != 0) begin
            acc += longint'(curve_icpt[seg]);
        end
        y = acc / 64'sd65536;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        r.smp    = x;
        r.shaped = y[SAMPLE_W-1:0];
        r.seg    = 4'(seg);
        return r;
    endfunction

    // Fold one accepted request into the predictor.
    task automatic apply_request(input t_request r);
        if (r.action == ACTION_LOAD) begin
            n_loads++;
            if (int'(r.seg_index) < SEGMENTS) begin
                curve_bp[r.seg_index]    = r.bp;
                curve_slope[r.seg_index] = r.slope;
                curve_icpt[r.seg_index]  = r.icpt;
            end
        end else begin
            n_samples++;
            shaped_q.push_back(shape_sample(r.smp));
        end
    endtask

    function automatic logic signed [ICPT_W-1:0] rand_icpt();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ICPT_W-1:0];
    endfunction

    // Loads carry random sample bits and samples carry random load fields, so
    // the fields that a request does not use are exercised too.
    task automatic push_load(input int idx, input logic signed [SAMPLE_W-1:0] bp,
                             input logic [SLOPE_W-1:0] slope,
                             input logic signed [ICPT_W-1:0] icpt, input bit drain);
        t_request r;
        r.action             = ACTION_LOAD;
        r.smp                = SAMPLE_W'($urandom());
        r.seg_index          = 4'(idx);
        r.bp                 = bp;
        r.slope              = slope;
        r.icpt               = icpt;
        r.hold_until_drained = drain;
        if (idx < SEGMENTS) begin
            gen_bp[idx] = bp;
        end
        pending_q.push_back(r);
        n_queued++;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input bit drain);
        t_request r;
        r.action             = ACTION_SHAPE;
        r.smp                = x;
        r.seg_index          = 4'($urandom());
        r.bp                 = SAMPLE_W'($urandom());
        r.slope              = SLOPE_W'($urandom());
        r.icpt               = rand_icpt();
        r.hold_until_drained = drain;
        pending_q.push_back(r);
        n_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        v = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5, 6: begin
                // Right on, just below or just above a segment edge.
                v = int'(gen_bp[$urandom_range(0, SEGMENTS - 1)])
                    + int'($urandom_range(0, 2)) - 1;
            end
            7: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 512)) - 256;
        endcase
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    // Load segments first..last with non-decreasing breakpoints. Intercepts either
    // keep the curve continuous at each breakpoint, as the host would
    // precompute them, or are fully random so the output saturates.
    task automatic push_curve(input int first, input int last, input bit reversed,
                              input bit drain);
        logic signed [SAMPLE_W-1:0] bps[SEGMENTS];
        logic [SLOPE_W-1:0]         slopes[SEGMENTS];
        logic signed [ICPT_W-1:0]   icpts[SEGMENTS];
        int                         bp;
        int                         bp_prev;
        longint                     y_q16;
        longint                     icpt_l;
        bit                         wild;
        int                         j;
        bp      = -32768 + int'($urandom_range(0, 4000));
        bp_prev = -32768;
        y_q16   = -longint'($urandom_range(0, 32767)) * 64'sd65536;
        wild    = ($urandom_range(0, 3) == 0);
        for (int k = first; k <= last; k++) begin
            bp += int'($urandom_range(0, 4400));
            if (bp > 32767) begin
                bp = 32767;
            end
            bps[k] = 16'(bp);
            slopes[k] = ($urandom_range(0, 1) != 0) ? 17'($urandom_range(0, 131071))
                                                    : 17'($urandom_range(0, 70000));
            if (wild) begin
                icpts[k] = rand_icpt();
            end else begin
                icpt_l = y_q16 - longint'(bp_prev) * longint'(slopes[k]);
                if (icpt_l > ICPT_MAX) begin
                    icpt_l = ICPT_MAX;
                end
                if (icpt_l < ICPT_MIN) begin
                    icpt_l = ICPT_MIN;
                end
                icpts[k] = icpt_l[ICPT_W-1:0];
                y_q16 = longint'(bp) * longint'(slopes[k]) + icpt_l;
                if (y_q16 > Y_LIMIT) begin
                    y_q16 = Y_LIMIT;
                end
                if (y_q16 < -Y_LIMIT) begin
                    y_q16 = -Y_LIMIT;
                end
            end
            bp_prev = bp;
        end
        for (int k = first; k <= last; k++) begin
            j = reversed ? (last - (k - first)) : k;
            push_load(j, bps[j], slopes[j], icpts[j], drain && (k == first));
        end
    endtask

    // Sender: bursts of random length separated by random gaps. The
    // predictor is updated at the edge where a request is accepted.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_request(cur_req);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].hold_until_drained && shaped_q.size() != 0)) begin
                    cur_req = pending_q.pop_front();
                    i_valid      <= 1'b1;
                    i_action     <= cur_req.action;
                    i_sample     <= cur_req.smp;
                    i_seg_index  <= cur_req.seg_index;
                    i_breakpoint <= cur_req.bp;
                    i_slope      <= cur_req.slope;
                    i_intercept  <= cur_req.icpt;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Now and then a long burst with no idling at all.
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 20);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between open, choppy and stingy modes.
    // Twice during the run it holds off for a long stretch so the chain fills
    // and the block must stall its input.
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       next_hold_at = 150;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (n_long_holds < 2 && n_results >= next_hold_at) begin
            n_long_holds++;
            next_hold_at = 450;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_CHOPPY: i_ready <= ($urandom_range(0, 1) != 0);
                default:   i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_shape_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            seg_seen[o_segment_used] = 1'b1;
            if (o_shaped == 16'sh7fff || o_shaped == 16'sh8000) begin
                n_saturated++;
            end
            if (shaped_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: shaped=%0d seg=%0d",
                                          o_shaped, o_segment_used));
            end else begin
                want = shaped_q.pop_front();
                if (o_shaped !== want.shaped) begin
                    report_mismatch($sformatf("sample %0d: shaped %0d, expected %0d",
                                              want.smp, o_shaped, want.shaped));
                end
                if (o_segment_used !== want.seg) begin
                    report_mismatch($sformatf("sample %0d: segment %0d, expected %0d",
                                              want.smp, o_segment_used, want.seg));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Run stopped by cycle limit with %0d results outstanding",
                     shaped_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int  kind;
        int  first;
        int  last;
        int  n_x;
        bit  drain;
        int  segs_hit;

        // Directed curve: breakpoints every 3000 from -30000 up to 15000, so
        // anything above 15000 falls through to the last segment.
        for (int j = 0; j < SEGMENTS; j++) begin
            case (j)
                // Segment 0 has zero gain and a maximal intercept that must be ignored.
                0:  push_load(j, 16'(-30000), '0, 35'(ICPT_MAX), 1'b0);
                // Full gain with the most negative intercept: saturates low.
                1:  push_load(j, 16'(-27000), 17'h1ffff, 35'(ICPT_MIN), 1'b0);
                // Unit slope: a sample of -1 must truncate toward zero, not down.
                10: push_load(j, 16'sd0, 17'd1, '0, 1'b0);
                // Full gain with the largest intercept: saturates high.
                15: push_load(j, 16'(-30000 + 3000 * j), 17'h1ffff, 35'(ICPT_MAX), 1'b0);
                default: push_load(j, 16'(-30000 + 3000 * j), 17'd65536,
                                   35'(-64'sd65536 * (j - 8)), 1'b0);
            endcase
        end
        push_sample(16'sh8000, 1'b0);
        push_sample(16'(-30000), 1'b0);
        push_sample(16'(-29999), 1'b0);
        push_sample(16'(-1), 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd15000, 1'b0);
        push_sample(16'sd15001, 1'b0);
        push_sample(16'sh7fff, 1'b0);

        // Random part. The whole curve is loaded above, so every sample is
        // legal. Most episodes reload a well-formed curve and then shape a
        // batch of samples; the rest are stray loads and partial reloads.
        drain = 1'b1;
        while (n_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                push_curve(0, SEGMENTS - 1, ($urandom_range(0, 4) == 0), drain);
                n_x = $urandom_range(10, 40);
            end else if (kind < 9) begin
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    push_load($urandom_range(0, SEGMENTS - 1), 16'($urandom()),
                              17'($urandom_range(0, 131071)), rand_icpt(), drain);
                    drain = 1'b0;
                end
                n_x = $urandom_range(5, 20);
            end else begin
                first = $urandom_range(0, SEGMENTS - 1);
                last  = $urandom_range(first, SEGMENTS - 1);
                push_curve(first, last, 1'b0, drain);
                n_x = $urandom_range(5, 20);
            end
            for (int k = 0; k < n_x; k++) begin
                push_sample(pick_sample(), 1'b0);
            end
            drain = ($urandom_range(0, 7) == 0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (shaped_q.size() != 0) begin
            @(posedge i_clk);
        end
        // Give trailing loads time to leave the chain and any stray result
        // time to show up.
        repeat (LATENCY + 20) @(posedge i_clk);
        if (shaped_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", shaped_q.size()));
        end

        segs_hit = 0;
        for (int j = 0; j < SEGMENTS; j++) begin
            segs_hit += seg_seen[j];
        end
        $display("Coverage: %0d segment loads, %0d samples shaped, %0d saturated outputs",
                 n_loads, n_samples, n_saturated);
        $display("Coverage: %0d of %0d segments applied, %0d long receiver hold-offs",
                 segs_hit, SEGMENTS, n_long_holds);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pws_pkg.sv
rtl/core/pws_cell.sv
rtl/core/pws_arith.sv
rtl/core/piecewise_waveshaper_search_unit.sv
dv/tb_piecewise_waveshaper_search_unit.sv
